// File: rtl/wwtps_pkg.sv
// ----------------------------------------------------------------------------
// wwtps_pkg
// Shared constants, types and byte helpers for the whole-word term scorer.
// ----------------------------------------------------------------------------
package wwtps_pkg;

  localparam int NUM_TERMS  = 4;
  localparam int TERM_LEN   = 8;
  localparam int HIST_DEPTH = TERM_LEN + 1;
  localparam int LEN_W      = 4;
  localparam int CNT_W      = 3;
  localparam int SEL_W      = $clog2(TERM_LEN);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int SCORE_W    = 32;
  localparam int ADJ_W      = 31;

  localparam logic [CFG_IDX_W-1:0] REG_TERM_CHARS_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_CHARS_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_CHARS_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_CHARS_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_LENGTHS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_COUNT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PENALTY_STEP = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_CEILING = 3'd7;

  localparam logic [SCORE_W-1:0] GATE_CEILING_RST = 32'h0001_0000;

  typedef logic [TERM_LEN-1:0][7:0]   term_t;
  typedef logic [NUM_TERMS-1:0][7:0]  want_t;

  // per-cell status toward the match logic
  typedef struct packed {
    logic                 occ_cur;
    logic                 occ_nxt;
    logic                 word_cur;
    logic                 word_nxt;
    logic [NUM_TERMS-1:0] eq_cur;
    logic [NUM_TERMS-1:0] eq_nxt;
  } cell_stat_t;

  // end-of-text request toward the score stage
  typedef struct packed {
    logic [CNT_W-1:0]   missing;
    logic [SCORE_W-1:0] fused;
    logic               gate;
  } score_req_t;

  function automatic logic [7:0] lower_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) r = c + 8'd32;
    return r;
  endfunction

  function automatic logic is_word_byte(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7a) ||
           (c >= 8'h41 && c <= 8'h5a) || (c == 8'h5f);
  endfunction

  function automatic term_t lower_term(input logic [CFG_DATA_W-1:0] v);
    term_t r;
    for (int k = 0; k < TERM_LEN; k++) r[k] = lower_byte(v[8*k +: 8]);
    return r;
  endfunction

endpackage

// File: rtl/whole_word_term_penalty_scorer.sv
// ----------------------------------------------------------------------------
// whole_word_term_penalty_scorer
// Streams text bytes through a row of history cells, flags whole-word,
// case-insensitive term hits and scores each text at its end.
// ----------------------------------------------------------------------------
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid, in_stall, text/valid/end/score/gate | request in
//  out     | out_valid, out_stall, adjusted_score, missing | result out
//  cfg     | cfg_we, cfg_index, cfg_wdata                  | write only
//
// One byte accepted per cycle while in_stall is low. A text's end request
// passes the term flags register, then the penalty/clamp output register.
// in_stall rises only when both score registers are full and out is stalled.
// Synchronous active-low reset clears history and flags, and resets config.
// ----------------------------------------------------------------------------
module whole_word_term_penalty_scorer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_text_char,
  input  logic                                 in_char_valid,
  input  logic                                 in_end_of_text,
  input  logic signed [wwtps_pkg::SCORE_W-1:0] in_fused_score,
  input  logic                                 in_gate_failed,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [wwtps_pkg::ADJ_W-1:0]          out_adjusted_score,
  output logic [wwtps_pkg::CNT_W-1:0]          out_missing_terms,
  input  logic                                 cfg_we,
  input  logic [wwtps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wwtps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import wwtps_pkg::*;

  // configuration
  term_t              term_r [NUM_TERMS];
  logic [LEN_W-1:0]   len_r  [NUM_TERMS];
  logic [CNT_W-1:0]   count_r;
  logic [SCORE_W-1:0] penalty_r;
  logic [SCORE_W-1:0] ceiling_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < NUM_TERMS; t++) begin
        term_r[t] <= '0;
        len_r[t]  <= '0;
      end
      count_r   <= '0;
      penalty_r <= '0;
      ceiling_r <= GATE_CEILING_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TERM_CHARS_0: term_r[0] <= lower_term(cfg_wdata);
        REG_TERM_CHARS_1: term_r[1] <= lower_term(cfg_wdata);
        REG_TERM_CHARS_2: term_r[2] <= lower_term(cfg_wdata);
        REG_TERM_CHARS_3: term_r[3] <= lower_term(cfg_wdata);
        REG_TERM_LENGTHS: begin
          for (int t = 0; t < NUM_TERMS; t++) begin
            len_r[t] <= (cfg_wdata[LEN_W*t +: LEN_W] > LEN_W'(TERM_LEN)) ?
                        LEN_W'(TERM_LEN) : cfg_wdata[LEN_W*t +: LEN_W];
          end
        end
        REG_TERM_COUNT: begin
          count_r <= (cfg_wdata[CNT_W-1:0] > CNT_W'(NUM_TERMS)) ?
                     CNT_W'(NUM_TERMS) : cfg_wdata[CNT_W-1:0];
        end
        REG_PENALTY_STEP: penalty_r <= cfg_wdata[SCORE_W-1:0];
        REG_GATE_CEILING: ceiling_r <= cfg_wdata[SCORE_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic       a_valid_r;
  score_req_t a_req_r;
  logic       b_ready;
  logic       acc;
  logic       shift;
  logic       clear;
  logic [7:0] lc;
  logic       lc_word;

  assign in_stall = a_valid_r && !b_ready;
  assign acc      = in_valid && !in_stall;
  assign lc       = lower_byte(in_text_char);
  assign lc_word  = is_word_byte(lc);
  assign shift    = acc && in_char_valid;
  assign clear    = acc && in_end_of_text;

  // cell row
  logic [7:0]  byte_chain [HIST_DEPTH+1];
  logic        occ_chain  [HIST_DEPTH+1];
  want_t       want       [HIST_DEPTH];
  cell_stat_t  stat       [HIST_DEPTH];

  assign byte_chain[0] = lc;
  assign occ_chain[0]  = 1'b1;

  // wanted byte at position i for term t is term char (len - 1 - i)
  always_comb begin
    logic [LEN_W-1:0] sel;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      for (int t = 0; t < NUM_TERMS; t++) begin
        sel = LEN_W'(len_r[t] - LEN_W'(1) - LEN_W'(i));
        want[i][t] = term_r[t][sel[SEL_W-1:0]];
      end
    end
  end

  for (genvar i = 0; i < HIST_DEPTH; i++) begin : g_cell
    wwtps_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift    (shift),
      .clear    (clear),
      .byte_in  (byte_chain[i]),
      .occ_in   (occ_chain[i]),
      .want     (want[i]),
      .byte_out (byte_chain[i+1]),
      .occ_out  (occ_chain[i+1]),
      .stat     (stat[i])
    );
  end

  // hits on the current history and on the history after this byte
  logic [NUM_TERMS-1:0] hit_pre;
  logic [NUM_TERMS-1:0] hit_post;
  logic [NUM_TERMS-1:0] found_r;
  logic [NUM_TERMS-1:0] found_all;
  logic [CNT_W-1:0]     missing;

  always_comb begin
    logic [LEN_W-1:0] l;
    logic [LEN_W-1:0] lm1;
    for (int t = 0; t < NUM_TERMS; t++) begin
      l   = len_r[t];
      lm1 = LEN_W'(l - LEN_W'(1));
      hit_pre[t]  = 1'b0;
      hit_post[t] = 1'b0;
      if (l != '0) begin
        hit_pre[t]  = stat[lm1].occ_cur && !stat[l].word_cur;
        hit_post[t] = stat[lm1].occ_nxt && !stat[l].word_nxt;
        for (int i = 0; i < TERM_LEN; i++) begin
          if (LEN_W'(i) < l) begin
            if (!stat[i].eq_cur[t]) hit_pre[t]  = 1'b0;
            if (!stat[i].eq_nxt[t]) hit_post[t] = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    found_all = found_r | hit_post;
    if (in_char_valid && !lc_word) found_all = found_all | hit_pre;
    missing = '0;
    for (int t = 0; t < NUM_TERMS; t++) begin
      if (CNT_W'(t) < count_r && len_r[t] != '0 && !found_all[t]) begin
        missing = missing + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      found_r <= '0;
    end else if (shift && !lc_word) begin
      found_r <= found_r | hit_pre;
    end
  end

  // term-flag stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (clear) begin
      a_valid_r <= 1'b1;
    end else if (b_ready) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      a_req_r.missing <= missing;
      a_req_r.fused   <= in_fused_score;
      a_req_r.gate    <= in_gate_failed;
    end
  end

  wwtps_score u_score (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (a_valid_r),
    .req                (a_req_r),
    .penalty_step       (penalty_r),
    .gate_ceiling       (ceiling_r),
    .req_ready          (b_ready),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_adjusted_score (out_adjusted_score),
    .out_missing_terms  (out_missing_terms)
  );

endmodule

// File: rtl/wwtps_cell.sv
// ----------------------------------------------------------------------------
// wwtps_cell
// One history position: holds a lower-cased byte and an occupied flag,
// shifts toward older positions and compares against the wanted bytes.
// ----------------------------------------------------------------------------
module wwtps_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  shift,
  input  logic                  clear,
  input  logic [7:0]            byte_in,
  input  logic                  occ_in,
  input  wwtps_pkg::want_t      want,
  output logic [7:0]            byte_out,
  output logic                  occ_out,
  output wwtps_pkg::cell_stat_t stat
);
  import wwtps_pkg::*;

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;
  logic       occ_r;
  logic       occ_nxt;

  assign byte_nxt = shift ? byte_in : byte_r;
  assign occ_nxt  = shift ? occ_in  : occ_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      byte_r <= '0;
      occ_r  <= 1'b0;
    end else begin
      byte_r <= byte_nxt;
      occ_r  <= occ_nxt;
    end
  end

  always_comb begin
    stat.occ_cur  = occ_r;
    stat.occ_nxt  = occ_nxt;
    stat.word_cur = is_word_byte(byte_r);
    stat.word_nxt = is_word_byte(byte_nxt);
    for (int t = 0; t < NUM_TERMS; t++) begin
      stat.eq_cur[t] = (byte_r == want[t]);
      stat.eq_nxt[t] = (byte_nxt == want[t]);
    end
  end

  assign byte_out = byte_r;
  assign occ_out  = occ_r;

endmodule

// File: rtl/wwtps_score.sv
// ----------------------------------------------------------------------------
// wwtps_score
// Output stage: applies the missing-term penalty, floors at zero, applies
// the gate ceiling when the gate failed and holds the result until taken.
// ----------------------------------------------------------------------------
module wwtps_score (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                req_valid,
  input  wwtps_pkg::score_req_t               req,
  input  logic [wwtps_pkg::SCORE_W-1:0]       penalty_step,
  input  logic [wwtps_pkg::SCORE_W-1:0]       gate_ceiling,
  output logic                                req_ready,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [wwtps_pkg::ADJ_W-1:0]         out_adjusted_score,
  output logic [wwtps_pkg::CNT_W-1:0]         out_missing_terms
);
  import wwtps_pkg::*;

  logic               valid_r;
  logic [ADJ_W-1:0]   score_r;
  logic [CNT_W-1:0]   missing_r;
  logic [33:0]        p4;
  logic [33:0]        p2;
  logic [33:0]        p1;
  logic [34:0]        prod;
  logic [35:0]        diff;
  logic [ADJ_W-1:0]   floored;
  logic [ADJ_W-1:0]   score_nxt;
  logic               load;

  assign req_ready = !valid_r || !out_stall;
  assign load      = req_valid && req_ready;

  always_comb begin
    p4   = req.missing[2] ? {penalty_step, 2'b00} : '0;
    p2   = req.missing[1] ? {1'b0, penalty_step, 1'b0} : '0;
    p1   = req.missing[0] ? {2'b00, penalty_step} : '0;
    prod = 35'(p4) + 35'(p2) + 35'(p1);
    diff = {{4{req.fused[SCORE_W-1]}}, req.fused} - {1'b0, prod};
    floored = diff[35] ? '0 : diff[ADJ_W-1:0];
    score_nxt = floored;
    if (req.gate && ({1'b0, floored} > gate_ceiling)) score_nxt = gate_ceiling[ADJ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      score_r   <= score_nxt;
      missing_r <= req.missing;
    end
  end

  assign out_valid          = valid_r;
  assign out_adjusted_score = score_r;
  assign out_missing_terms  = missing_r;

endmodule
